### design/ovl_pkg.sv
package ovl_pkg;

   localparam logic [1:0] OP_FRONT  = 2'd0;
   localparam logic [1:0] OP_BACK   = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NOMATCH = 2'd2;

   localparam logic [2:0] MODE_HOLD  = 3'd0;
   localparam logic [2:0] MODE_FRONT = 3'd1;
   localparam logic [2:0] MODE_BACK  = 3'd2;
   localparam logic [2:0] MODE_LOAD  = 3'd3;
   localparam logic [2:0] MODE_PROP  = 3'd4;
   localparam logic [2:0] MODE_SHIFT = 3'd5;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         entry_count;
      logic               head_present;
      logic signed [31:0] head_value;
   } rsp_type;

   typedef struct packed {
      logic [2:0] mode;
   } cell_ctl_type;

endpackage

### design/ovl_cell.sv
module ovl_cell #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ovl_pkg::cell_ctl_type ctl,
   input  logic [VALUE_BITS-1:0] item_val,
   input  logic [VALUE_BITS-1:0] prev_value,
   input  logic                  prev_valid,
   input  logic                  prev_pre,
   input  logic [VALUE_BITS-1:0] next_value,
   input  logic                  next_valid,
   output logic [VALUE_BITS-1:0] value,
   output logic                  valid,
   output logic                  pre
);

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  valid_ff, valid_in;
   logic                  pre_ff, pre_in;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      pre_in   = pre_ff;
      case (ctl.mode)
         ovl_pkg::MODE_FRONT: begin
            value_in = prev_value;
            valid_in = prev_valid;
            pre_in   = 1'b0;
         end
         ovl_pkg::MODE_BACK: begin
            // first empty cell behind a full one takes the value
            if (!valid_ff && prev_valid) begin
               value_in = item_val;
               valid_in = 1'b1;
            end
            pre_in = 1'b0;
         end
         ovl_pkg::MODE_LOAD: begin
            pre_in = valid_ff && (value_ff == item_val);
         end
         ovl_pkg::MODE_PROP: begin
            pre_in = pre_ff | prev_pre;
         end
         ovl_pkg::MODE_SHIFT: begin
            // close the gap: every cell at or behind the first match advances
            if (pre_ff) begin
               value_in = next_value;
               valid_in = next_valid;
            end
            pre_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
         pre_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pre_ff   <= pre_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;
   assign pre   = pre_ff;

endmodule

### design/ordered_value_list.sv
// Ordered list of up to DEPTH signed values held packed in a row of cells, cell 0 being the
// head. A front or back insert, a rejected insert and an unused op write their result to
// the output register at the end of the request transfer cycle. In a remove, all cells
// compare in the transfer cycle, then the first-match flag moves down the row one cell per
// cycle in the propagate state, then the shift state closes the gap behind the match.
// The next request is taken once no remove is in progress and the result register is free.
module ordered_value_list #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ovl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ovl_pkg::rsp_type rsp_data
);

   localparam int LEN_BITS = $clog2(DEPTH + 1);
   localparam int CNT_BITS = $clog2(DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROP  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [LEN_BITS-1:0] length_ff, length_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ovl_pkg::rsp_type    rsp_ff, rsp_in;

   logic [VALUE_BITS-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]      cell_valid;
   logic [DEPTH-1:0]      cell_pre;
   logic [VALUE_BITS-1:0] prev_value [DEPTH];
   logic [DEPTH-1:0]      prev_valid;
   logic [DEPTH-1:0]      prev_pre;
   logic [VALUE_BITS-1:0] next_value [DEPTH];
   logic [DEPTH-1:0]      next_valid;

   ovl_pkg::cell_ctl_type ctl;
   logic [VALUE_BITS-1:0] item_val;
   logic                  accept;
   logic                  full;
   logic                  found;
   logic                  new_head_valid;
   logic [VALUE_BITS-1:0] new_head_value;

   assign item_val  = VALUE_BITS'(req_data.item_value);
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign full      = cell_valid[DEPTH-1];
   assign found     = cell_pre[DEPTH-1];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prev_value[i] = item_val;
         assign prev_valid[i] = 1'b1;
         assign prev_pre[i]   = 1'b0;
      end else begin : g_rest
         assign prev_value[i] = cell_value[i-1];
         assign prev_valid[i] = cell_valid[i-1];
         assign prev_pre[i]   = cell_pre[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_value[i] = '0;
         assign next_valid[i] = 1'b0;
      end else begin : g_inner
         assign next_value[i] = cell_value[i+1];
         assign next_valid[i] = cell_valid[i+1];
      end

      ovl_cell #(
         .VALUE_BITS(VALUE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .item_val  (item_val),
         .prev_value(prev_value[i]),
         .prev_valid(prev_valid[i]),
         .prev_pre  (prev_pre[i]),
         .next_value(next_value[i]),
         .next_valid(next_valid[i]),
         .value     (cell_value[i]),
         .valid     (cell_valid[i]),
         .pre       (cell_pre[i])
      );
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      length_in      = length_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      ctl.mode       = ovl_pkg::MODE_HOLD;
      new_head_valid = cell_valid[0];
      new_head_value = cell_value[0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.status = ovl_pkg::STATUS_DONE;
               if (req_data.op == ovl_pkg::OP_FRONT || req_data.op == ovl_pkg::OP_BACK) begin
                  if (full) begin
                     rsp_in.status = ovl_pkg::STATUS_FULL;
                  end else begin
                     ctl.mode  = (req_data.op == ovl_pkg::OP_FRONT) ?
                                 ovl_pkg::MODE_FRONT : ovl_pkg::MODE_BACK;
                     length_in = length_ff + LEN_BITS'(1);
                     if (req_data.op == ovl_pkg::OP_FRONT || !cell_valid[0]) begin
                        new_head_valid = 1'b1;
                        new_head_value = item_val;
                     end
                  end
               end
               if (req_data.op == ovl_pkg::OP_REMOVE) begin
                  ctl.mode = ovl_pkg::MODE_LOAD;
                  cnt_in   = '0;
                  state_in = ST_PROP;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_PROP: begin
            ctl.mode = ovl_pkg::MODE_PROP;
            cnt_in   = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(DEPTH - 2)) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            ctl.mode     = ovl_pkg::MODE_SHIFT;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (found) begin
               rsp_in.status = ovl_pkg::STATUS_DONE;
               length_in     = length_ff - LEN_BITS'(1);
            end else begin
               rsp_in.status = ovl_pkg::STATUS_NOMATCH;
            end
            if (cell_pre[0]) begin
               new_head_valid = cell_valid[1];
               new_head_value = cell_value[1];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) begin
         rsp_in.entry_count  = 5'(length_in);
         rsp_in.head_present = new_head_valid;
         rsp_in.head_value   = new_head_valid ? 32'($signed(new_head_value)) : '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_length_matches: assert property (@(posedge clock) disable iff (reset)
      LEN_BITS'($countones(cell_valid)) == length_ff)
      else $error("length disagrees with valid cells");

   a_packed: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
      else $error("valid cells not packed at the head");

   a_no_rsp_in_remove: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending during remove");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && full && req_data.op != ovl_pkg::OP_REMOVE) |=> $stable(length_ff))
      else $error("rejected insert changed the list");

endmodule

### test/ovl_checker.sv
module ovl_checker #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  ovl_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  ovl_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               reports_outstanding
);

   logic signed [31:0] shadow_entries[$];
   ovl_pkg::rsp_type   awaited_reports[$];

   // Apply one request to the shadow list and return the report it should give.
   function automatic ovl_pkg::rsp_type apply_list_request(ovl_pkg::req_type req);
      ovl_pkg::rsp_type rep;
      int               idx;
      bit               found;
      rep.status = ovl_pkg::STATUS_DONE;
      case (req.op)
         ovl_pkg::OP_FRONT, ovl_pkg::OP_BACK: begin
            if (shadow_entries.size() >= DEPTH) begin
               rep.status = ovl_pkg::STATUS_FULL;
            end else if (req.op == ovl_pkg::OP_FRONT) begin
               shadow_entries.push_front(req.item_value);
            end else begin
               shadow_entries.push_back(req.item_value);
            end
         end
         ovl_pkg::OP_REMOVE: begin
            found = 1'b0;
            idx   = 0;
            while (!found && idx < shadow_entries.size()) begin
               if (shadow_entries[idx] == req.item_value) found = 1'b1;
               else idx++;
            end
            if (found) shadow_entries.delete(idx);
            else rep.status = ovl_pkg::STATUS_NOMATCH;
         end
         default: begin
            // unused code: list untouched, report current state
         end
      endcase
      rep.entry_count  = 5'(shadow_entries.size());
      rep.head_present = (shadow_entries.size() > 0);
      rep.head_value   = (shadow_entries.size() > 0) ? shadow_entries[0] : 32'sd0;
      return rep;
   endfunction

   task automatic report_field(string what, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      ovl_pkg::rsp_type want;
      if (reset) begin
         shadow_entries.delete();
         awaited_reports.delete();
         mismatch_count = 0;
      end else begin
         // A report always belongs to an earlier transfer, so check before predicting.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_reports.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected report, expected none, actual %h", $time, rsp_data);
            end else begin
               want = awaited_reports.pop_front();
               report_field("status", want.status, rsp_data.status);
               report_field("entry_count", want.entry_count, rsp_data.entry_count);
               report_field("head_present", want.head_present, rsp_data.head_present);
               report_field("head_value", want.head_value, rsp_data.head_value);
            end
         end
         if (req_valid && !req_stall) awaited_reports.push_back(apply_list_request(req_data));
      end
      reports_outstanding = awaited_reports.size();
   end

endmodule

### test/tb_ordered_value_list.sv
module tb_ordered_value_list;

   localparam int         DEPTH       = 16;
   localparam int         ITEM_TOTAL  = 1200;
   localparam int         HOLD_CYCLES = 150;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   ovl_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   ovl_pkg::rsp_type rsp_data;
   int               mismatch_count;
   int               reports_outstanding;
   bit               quiet;
   bit               hold_off_request;

   logic signed [31:0] value_pool[8] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1,
                                         32'sd1, 32'sd5, -32'sd5, 32'sd12345};

   ordered_value_list #(.DEPTH(DEPTH), .VALUE_BITS(32)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   ovl_checker #(.DEPTH(DEPTH)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .mismatch_count(mismatch_count), .reports_outstanding(reports_outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Offer one request and hold it until the transfer.
   task automatic send_request(logic [1:0] op, logic signed [31:0] value);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{op: op, item_value: value};
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
   endtask

   task automatic idle_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [1:0] pick_op(mix_type mix);
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  return (roll < 45) ? ovl_pkg::OP_FRONT : (roll < 90) ? ovl_pkg::OP_BACK :
                           (roll < 97) ? ovl_pkg::OP_REMOVE : OP_UNUSED;
         MIX_DRAIN: return (roll < 10) ? ovl_pkg::OP_FRONT : (roll < 20) ? ovl_pkg::OP_BACK :
                           (roll < 96) ? ovl_pkg::OP_REMOVE : OP_UNUSED;
         default:   return (roll < 30) ? ovl_pkg::OP_FRONT : (roll < 60) ? ovl_pkg::OP_BACK :
                           (roll < 95) ? ovl_pkg::OP_REMOVE : OP_UNUSED;
      endcase
   endfunction

   // Receiver: random stall bursts, one long hold-off on request, none at the end.
   initial begin
      int cycles;
      bit hold_done;
      rsp_stall = 1'b0;
      hold_done = 1'b0;
      forever begin
         if (hold_off_request && !hold_done) begin
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
            hold_done = 1'b1;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            cycles = $urandom_range(1, 8);
            repeat (cycles) begin
               @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end else begin
            cycles = $urandom_range(1, 6);
            repeat (cycles) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      mix_type mix;
      int      segment_left;
      quiet            = 1'b0;
      hold_off_request = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      mix              = MIX_EVEN;
      segment_left     = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty list: remove misses, unused code reports nothing held.
      send_request(ovl_pkg::OP_REMOVE, 32'sd7);
      send_request(OP_UNUSED, 32'sd7);
      send_request(ovl_pkg::OP_FRONT, 32'sh8000_0000);
      send_request(ovl_pkg::OP_BACK, 32'sh7fff_ffff);
      send_request(OP_UNUSED, -32'sd1);
      send_request(ovl_pkg::OP_FRONT, -32'sd1);
      send_request(ovl_pkg::OP_BACK, 32'sd0);
      send_request(ovl_pkg::OP_FRONT, 32'sd5);
      send_request(ovl_pkg::OP_BACK, 32'sd5);
      // Duplicates: only the frontmost copy goes.
      send_request(ovl_pkg::OP_REMOVE, 32'sd5);
      send_request(ovl_pkg::OP_REMOVE, 32'sd99);
      for (int k = 0; k < 11; k++) begin
         send_request(k[0] ? ovl_pkg::OP_FRONT : ovl_pkg::OP_BACK, 32'(k) <<< 27);
      end
      // Full list rejects inserts at either end.
      send_request(ovl_pkg::OP_FRONT, 32'sd77);
      send_request(ovl_pkg::OP_BACK, 32'sd77);
      send_request(OP_UNUSED, 32'sd77);
      send_request(ovl_pkg::OP_REMOVE, 32'sh7fff_ffff);
      send_request(ovl_pkg::OP_REMOVE, 32'sh5000_0000);
      send_request(ovl_pkg::OP_REMOVE, 32'sh4000_0000);

      for (int n = 0; n < ITEM_TOTAL; n++) begin
         if (segment_left == 0) begin
            mix          = mix_type'($urandom_range(0, 2));
            segment_left = $urandom_range(20, 80);
         end
         segment_left--;
         if (n == 400) hold_off_request = 1'b1;
         if (n == 700) begin
            idle_sender(1);
            wait (reports_outstanding == 0);
         end
         if (n == 1050) quiet = 1'b1;
         if (!quiet && $urandom_range(0, 4) == 0) idle_sender($urandom_range(1, 6));
         send_request(pick_op(mix), pick_value());
      end

      idle_sender(1);
      wait (reports_outstanding == 0);
      repeat (DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && reports_outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
